[sv/sms_pkg.sv]
// Package: constants, mode and register codes and shared types for the substring matcher.
`timescale 1ns / 1ps
`default_nettype none

package sms_pkg;

    localparam int MAX_PATTERN_BYTES = 8;
    localparam int BYTE_W            = 8;
    localparam int PAT_W             = MAX_PATTERN_BYTES * BYTE_W;
    localparam int LEN_W             = 4;
    localparam int MODE_W            = 3;
    localparam int VAL_W             = 16;
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 64;

    localparam logic [VAL_W-1:0] SAT16 = {VAL_W{1'b1}};

    localparam logic [MODE_W-1:0] MODE_DETECT      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FIRST_START = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FIRST_END   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_COUNT       = 3'd3;
    localparam logic [MODE_W-1:0] MODE_NTH_START   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_NTH_END     = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET  = 2'd3;

    typedef struct packed {
        logic step;   // word accepted while no answer given yet
        logic flush;  // word accepted carries the last-byte mark
    } cell_ctrl_t;

endpackage

`default_nettype wire

[sv/sms_text_if.sv]
// Interface: input channel carrying one text byte and its last-byte mark.
`timescale 1ns / 1ps
`default_nettype none

interface sms_text_if import sms_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;
    logic              last_byte;

    modport source (output valid, output text_byte, output last_byte, input ready);
    modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

`default_nettype wire

[sv/sms_answer_if.sv]
// Interface: output channel carrying the found flag and the answer value.
`timescale 1ns / 1ps
`default_nettype none

interface sms_answer_if import sms_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             found;
    logic [VAL_W-1:0] answer_value;

    modport source (output valid, output found, output answer_value, input ready);
    modport sink   (input valid, input found, input answer_value, output ready);
endinterface

`default_nettype wire

[sv/sms_cell.sv]
// Match cell: one pattern byte compare and the partial-match token for that place.
`timescale 1ns / 1ps
`default_nettype none

module sms_cell import sms_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cell_ctrl_t        ctrl,
    input  wire logic [BYTE_W-1:0] text_byte,
    input  wire logic [BYTE_W-1:0] pat_byte,
    input  wire logic              in_use,
    input  wire logic              is_end,
    input  wire logic              tok_ext,
    input  wire logic              tok_in,
    output logic                   tok,
    output logic                   carry,
    output logic                   done
);

    logic tok_reg;
    logic tok_next;
    logic own;
    logic hit;

    assign own   = (tok_reg | tok_ext) & in_use;
    assign hit   = own & (text_byte == pat_byte);
    assign carry = hit & ~is_end;
    assign done  = hit & is_end;
    assign tok   = tok_reg;

    always_comb
    begin
        tok_next = tok_reg;
        if (ctrl.flush)
        begin
            tok_next = 1'b0;
        end
        else if (ctrl.step)
        begin
            tok_next = tok_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

endmodule

`default_nettype wire

[sv/substring_match_stream_unit.sv]
// Top level: streaming substring matcher built from a chain of match cells.
//
// Text enters on the text channel, one byte per word, the final byte of a
// string marked by last_byte. The pattern (1 to 8 bytes), its length, the
// search mode and the target occurrence are set through the write port
// (cfg_we, cfg_index, cfg_data) while the block is idle.
// Each accepted byte is compared in the same cycle by every cell; the
// partial-match token moves one cell along on a hit. One byte per cycle is
// taken while text.ready is high, with no gap between strings.
// At most one answer word per string: at the deciding byte when the request
// is settled early (the rest of the string is absorbed), otherwise at the
// last byte. The answer word is registered into the output buffer when the
// deciding byte is accepted.
// Answers go through a two-entry output buffer: a stalled receiver holds the
// front word, a second answer waits in the skid entry, and only when both are
// full is text.ready dropped.
// Reset clears all string state and sets the registers to pattern 0, length
// one, detect mode and first occurrence.
`timescale 1ns / 1ps
`default_nettype none

module substring_match_stream_unit import sms_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    sms_text_if.sink                   text,
    sms_answer_if.source               answer,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [PAT_W-1:0]  pattern_reg;
    logic [LEN_W-1:0]  length_reg;
    logic [MODE_W-1:0] mode_reg;
    logic [VAL_W-1:0]  target_reg;

    logic [VAL_W-1:0]  pos_reg,   pos_next;
    logic [VAL_W-1:0]  count_reg, count_next;
    logic              given_reg, given_next;

    logic              out_valid_reg, out_valid_next;
    logic              out_found_reg, out_found_next;
    logic [VAL_W-1:0]  out_value_reg, out_value_next;
    logic              skid_valid_reg, skid_valid_next;
    logic              skid_found_reg, skid_found_next;
    logic [VAL_W-1:0]  skid_value_reg, skid_value_next;

    logic [LEN_W-1:0]  len_c;
    logic              accept;
    cell_ctrl_t        ctrl;

    logic [MAX_PATTERN_BYTES-1:0] in_use;
    logic [MAX_PATTERN_BYTES-1:0] is_end;
    logic [MAX_PATTERN_BYTES-1:0] tok;
    logic [MAX_PATTERN_BYTES-1:0] tok_in;
    logic [MAX_PATTERN_BYTES-1:0] carry;
    logic [MAX_PATTERN_BYTES-1:0] done;
    logic                         any_tok;
    logic                         match;
    logic                         restart;

    logic [VAL_W-1:0]  start_pos;
    logic              nth_hit;
    logic              mode_early;
    logic [VAL_W-1:0]  early_value;
    logic              early_emit;
    logic              final_emit;
    logic              emit;
    logic              res_found;
    logic [VAL_W-1:0]  res_value;
    logic              pop;

    // length 0 reads as 1, above the cell count as the cell count
    always_comb
    begin
        if (length_reg == '0)
        begin
            len_c = LEN_W'(1);
        end
        else if (length_reg > LEN_W'(MAX_PATTERN_BYTES))
        begin
            len_c = LEN_W'(MAX_PATTERN_BYTES);
        end
        else
        begin
            len_c = length_reg;
        end
    end

    assign text.ready  = ~skid_valid_reg;
    assign accept      = text.valid & text.ready;
    assign ctrl.step   = accept & ~given_reg;
    assign ctrl.flush  = accept & text.last_byte;

    assign any_tok = |(tok & in_use);
    assign match   = |done;
    assign restart = ~match & ~(|carry) & (text.text_byte == pattern_reg[BYTE_W-1:0]);

    genvar k;
    generate
        for (k = 0; k < MAX_PATTERN_BYTES; k++)
        begin : g_cell
            assign in_use[k] = LEN_W'(k) < len_c;
            assign is_end[k] = LEN_W'(k) == (len_c - LEN_W'(1));

            if (k == 0)
            begin : g_head
                assign tok_in[k] = 1'b0;
            end
            else if (k == 1)
            begin : g_second
                assign tok_in[k] = carry[k-1] | restart;
            end
            else
            begin : g_rest
                assign tok_in[k] = carry[k-1];
            end

            sms_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .text_byte (text.text_byte),
                .pat_byte  (pattern_reg[k*BYTE_W +: BYTE_W]),
                .in_use    (in_use[k]),
                .is_end    (is_end[k]),
                .tok_ext   ((k == 0) ? ~any_tok : 1'b0),
                .tok_in    (tok_in[k]),
                .tok       (tok[k]),
                .carry     (carry[k]),
                .done      (done[k])
            );
        end
    endgenerate

    assign start_pos = (pos_reg == SAT16) ? SAT16 : pos_reg - VAL_W'(len_c - LEN_W'(1));
    assign nth_hit   = (target_reg != '0) && (count_reg == target_reg - VAL_W'(1));

    always_comb
    begin
        mode_early  = 1'b0;
        early_value = '0;
        case (mode_reg)
            MODE_DETECT:
            begin
                mode_early = 1'b1;
            end
            MODE_FIRST_START:
            begin
                mode_early  = 1'b1;
                early_value = start_pos;
            end
            MODE_FIRST_END:
            begin
                mode_early  = 1'b1;
                early_value = pos_reg;
            end
            MODE_NTH_START:
            begin
                mode_early  = nth_hit;
                early_value = start_pos;
            end
            MODE_NTH_END:
            begin
                mode_early  = nth_hit;
                early_value = pos_reg;
            end
            default:
            begin
                mode_early = 1'b0;
            end
        endcase
    end

    assign early_emit = ctrl.step & match & mode_early;

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.step && match && !mode_early && count_reg != SAT16)
        begin
            count_next = count_reg + VAL_W'(1);
        end
    end

    assign final_emit = ctrl.flush & ~early_emit & ~given_reg;
    assign emit       = early_emit | final_emit;
    assign res_found  = early_emit | (mode_reg == MODE_COUNT);
    assign res_value  = early_emit ? early_value :
                        ((mode_reg == MODE_COUNT) ? count_next : '0);

    // string state
    always_comb
    begin
        pos_next   = pos_reg;
        given_next = given_reg;
        if (ctrl.flush)
        begin
            pos_next   = '0;
            given_next = 1'b0;
        end
        else
        begin
            if (accept && pos_reg != SAT16)
            begin
                pos_next = pos_reg + VAL_W'(1);
            end
            if (early_emit)
            begin
                given_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            count_reg <= '0;
            given_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            count_reg <= ctrl.flush ? '0 : count_next;
            given_reg <= given_next;
        end
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            length_reg  <= LEN_W'(1);
            mode_reg    <= MODE_DETECT;
            target_reg  <= VAL_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PATTERN: pattern_reg <= cfg_data[PAT_W-1:0];
                CFG_LENGTH:  length_reg  <= cfg_data[LEN_W-1:0];
                CFG_MODE:    mode_reg    <= cfg_data[MODE_W-1:0];
                CFG_TARGET:  target_reg  <= cfg_data[VAL_W-1:0];
                default:     pattern_reg <= pattern_reg;
            endcase
        end
    end

    // output buffer: front word plus skid entry
    assign pop = out_valid_reg & answer.ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_found_next  = out_found_reg;
        out_value_next  = out_value_reg;
        skid_valid_next = skid_valid_reg;
        skid_found_next = skid_found_reg;
        skid_value_next = skid_value_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_found_next  = skid_found_reg;
                out_value_next  = skid_value_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (emit && (!out_valid_reg || pop))
        begin
            out_valid_next = 1'b1;
            out_found_next = res_found;
            out_value_next = res_value;
        end
        else if (emit)
        begin
            skid_valid_next = 1'b1;
            skid_found_next = res_found;
            skid_value_next = res_value;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_found_reg  <= out_found_next;
        out_value_reg  <= out_value_next;
        skid_found_reg <= skid_found_next;
        skid_value_reg <= skid_value_next;
    end

    assign answer.valid        = out_valid_reg;
    assign answer.found        = out_found_reg;
    assign answer.answer_value = out_value_reg;

    // checks
    a_token_single: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok))
        else $error("more than one partial-match token");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && text.last_byte |=> !given_reg && pos_reg == '0 && count_reg == '0 && tok == '0)
        else $error("string state not cleared after last byte");

    a_skid_behind_front: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a word while front is empty");

    a_given_no_step: assert property (@(posedge clk) disable iff (!rst_n)
        given_reg && accept && !text.last_byte |=> given_reg && $stable(tok))
        else $error("match state moved after early answer");

endmodule

`default_nettype wire
